/* src/cfc_pkg.sv */
// Shared constants, types and the invariant step table for the conic fit block.
package cfc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int Q_W         = 64;
    localparam int TOL_W       = 32;
    localparam int KIND_W      = 4;
    localparam int NROW        = 5;
    localparam int NCOL        = 6;
    localparam int MEM_DEPTH   = 64;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int PROG_LEN    = 22;
    localparam int PC_W        = $clog2(PROG_LEN);

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd16;

    localparam logic signed [Q_W-1:0] Q_ONE     = 64'sh0000_0001_0000_0000;
    localparam logic signed [Q_W-1:0] Q_HALF    = 64'sh0000_0000_8000_0000;
    localparam logic signed [Q_W-1:0] Q_NEG_ONE = -Q_ONE;

    localparam logic [KIND_W-1:0] KIND_COINCIDENT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IMAG_PAR   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PARALLEL   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PARABOLA   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_POINT      = 4'd4;
    localparam logic [KIND_W-1:0] KIND_ELLIPSE    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_IMAG_ELL   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CROSSING   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_HYPERBOLA  = 4'd8;

    // scratch map: matrix rows at 0..29, then solution and temporaries
    localparam logic [MEM_AW-1:0] A_S0   = 6'd30;
    localparam logic [MEM_AW-1:0] A_S1   = 6'd31;
    localparam logic [MEM_AW-1:0] A_S2   = 6'd32;
    localparam logic [MEM_AW-1:0] A_S3   = 6'd33;
    localparam logic [MEM_AW-1:0] A_S4   = 6'd34;
    localparam logic [MEM_AW-1:0] A_A12  = 6'd35;
    localparam logic [MEM_AW-1:0] A_B1   = 6'd36;
    localparam logic [MEM_AW-1:0] A_B2   = 6'd37;
    localparam logic [MEM_AW-1:0] A_I1   = 6'd38;
    localparam logic [MEM_AW-1:0] A_I2   = 6'd39;
    localparam logic [MEM_AW-1:0] A_I3   = 6'd40;
    localparam logic [MEM_AW-1:0] A_K    = 6'd41;
    localparam logic [MEM_AW-1:0] A_T    = 6'd42;
    localparam logic [MEM_AW-1:0] A_U    = 6'd43;
    localparam logic [MEM_AW-1:0] A_V    = 6'd44;
    localparam logic [MEM_AW-1:0] A_HALF = 6'd45;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic                    start;
        t_alu_op                 op;
        logic signed [Q_W-1:0]   a;
        logic signed [Q_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic                    done;
        logic signed [Q_W-1:0]   res;
    } t_alu_rsp;

    typedef struct packed {
        t_alu_op            op;
        logic [MEM_AW-1:0]  a;
        logic [MEM_AW-1:0]  b;
        logic [MEM_AW-1:0]  dst;
    } t_ustep;

    function automatic t_ustep prog_step(input logic [PC_W-1:0] pc);
        case (pc)
            5'd0:    return '{ALU_MUL, A_S1,  A_HALF, A_A12};
            5'd1:    return '{ALU_MUL, A_S3,  A_HALF, A_B1};
            5'd2:    return '{ALU_MUL, A_S4,  A_HALF, A_B2};
            5'd3:    return '{ALU_ADD, A_S0,  A_S2,   A_I1};
            5'd4:    return '{ALU_MUL, A_S0,  A_S2,   A_T};
            5'd5:    return '{ALU_MUL, A_A12, A_A12,  A_U};
            5'd6:    return '{ALU_SUB, A_T,   A_U,    A_I2};
            5'd7:    return '{ALU_ADD, A_A12, A_A12,  A_V};
            5'd8:    return '{ALU_MUL, A_V,   A_B2,   A_V};
            5'd9:    return '{ALU_MUL, A_V,   A_B1,   A_V};
            5'd10:   return '{ALU_ADD, A_T,   A_V,    A_T};
            5'd11:   return '{ALU_MUL, A_S2,  A_B1,   A_V};
            5'd12:   return '{ALU_MUL, A_V,   A_B1,   A_V};
            5'd13:   return '{ALU_SUB, A_T,   A_V,    A_T};
            5'd14:   return '{ALU_SUB, A_T,   A_U,    A_T};
            5'd15:   return '{ALU_MUL, A_S0,  A_B2,   A_V};
            5'd16:   return '{ALU_MUL, A_V,   A_B2,   A_V};
            5'd17:   return '{ALU_SUB, A_T,   A_V,    A_I3};
            5'd18:   return '{ALU_MUL, A_B1,  A_B1,   A_V};
            5'd19:   return '{ALU_SUB, A_I1,  A_V,    A_K};
            5'd20:   return '{ALU_MUL, A_B2,  A_B2,   A_V};
            5'd21:   return '{ALU_SUB, A_K,   A_V,    A_K};
            default: return '{ALU_ADD, A_T,   A_T,    A_T};
        endcase
    endfunction

endpackage

/* src/cfc_if.sv */
// Request and result channel interfaces.
interface cfc_in_if #(
    parameter int COORD_WIDTH = cfc_pkg::COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x0;
    logic signed [COORD_WIDTH-1:0] y0;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic signed [COORD_WIDTH-1:0] x2;
    logic signed [COORD_WIDTH-1:0] y2;
    logic signed [COORD_WIDTH-1:0] x3;
    logic signed [COORD_WIDTH-1:0] y3;
    logic signed [COORD_WIDTH-1:0] x4;
    logic signed [COORD_WIDTH-1:0] y4;

    modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, x4, y4, input ready);
    modport sink   (input valid, x0, y0, x1, y1, x2, y2, x3, y3, x4, y4, output ready);
endinterface

interface cfc_out_if ();
    logic                               valid;
    logic                               ready;
    logic [cfc_pkg::KIND_W-1:0]         conic_kind;
    logic                               singular;
    logic signed [cfc_pkg::Q_W-1:0]     inv_trace;
    logic signed [cfc_pkg::Q_W-1:0]     inv_quad_det;
    logic signed [cfc_pkg::Q_W-1:0]     inv_full_det;
    logic signed [cfc_pkg::Q_W-1:0]     inv_semi;

    modport source (output valid, conic_kind, singular, inv_trace, inv_quad_det,
                    inv_full_det, inv_semi, input ready);
    modport sink   (input valid, conic_kind, singular, inv_trace, inv_quad_det,
                    inv_full_det, inv_semi, output ready);
endinterface

/* src/cfc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/cfc_alu.sv */
// Shared Q32.32 saturating add/sub, four-step multiplier and radix-2 divider.
module cfc_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfc_pkg::t_alu_req i_req,
    output cfc_pkg::t_alu_rsp o_rsp
);
    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_MFIN,
        A_DIV,
        A_DFIN
    } t_astate;

    t_astate       r_state;
    logic          r_done;
    logic [63:0]   r_res;
    logic [63:0]   r_ua;
    logic [63:0]   r_ub;
    logic          r_neg;
    logic [2:0]    r_mcnt;
    logic [63:0]   r_pp;
    logic [1:0]    r_ppsh;
    logic [127:0]  r_acc;
    logic [63:0]   r_rem;
    logic [63:0]   r_lo;
    logic [63:0]   r_q;
    logic [5:0]    r_dcnt;

    logic [63:0]   ua;
    logic [63:0]   ub;
    logic          neg;
    logic [64:0]   sum;
    logic [64:0]   dif;
    logic [64:0]   rr;
    logic [31:0]   pa;
    logic [31:0]   pb;
    logic [1:0]    psh;

    function automatic logic [63:0] from_mag(input logic n, input logic [63:0] m);
        if (n) begin
            return m[63] ? 64'h8000_0000_0000_0000 : (64'd0 - m);
        end
        return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    endfunction

    function automatic logic [63:0] sat65(input logic [64:0] s);
        if (s[64] != s[63]) begin
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    always_comb begin
        ua  = i_req.a[63] ? (64'd0 - i_req.a) : i_req.a;
        ub  = i_req.b[63] ? (64'd0 - i_req.b) : i_req.b;
        neg = i_req.a[63] ^ i_req.b[63];
        sum = {i_req.a[63], i_req.a} + {i_req.b[63], i_req.b};
        dif = {i_req.a[63], i_req.a} - {i_req.b[63], i_req.b};
        rr  = {r_rem, r_lo[63]};
        case (r_mcnt)
            3'd0:    begin pa = r_ua[31:0];  pb = r_ub[31:0];  psh = 2'd0; end
            3'd1:    begin pa = r_ua[31:0];  pb = r_ub[63:32]; psh = 2'd1; end
            3'd2:    begin pa = r_ua[63:32]; pb = r_ub[31:0];  psh = 2'd1; end
            default: begin pa = r_ua[63:32]; pb = r_ub[63:32]; psh = 2'd2; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_ua  <= ua;
                        r_ub  <= ub;
                        r_neg <= neg;
                        case (i_req.op)
                            cfc_pkg::ALU_ADD: begin
                                r_res  <= sat65(sum);
                                r_done <= 1'b1;
                            end
                            cfc_pkg::ALU_SUB: begin
                                r_res  <= sat65(dif);
                                r_done <= 1'b1;
                            end
                            cfc_pkg::ALU_MUL: begin
                                r_mcnt  <= 3'd0;
                                r_acc   <= '0;
                                r_state <= A_MUL;
                            end
                            default: begin
                                if (ub == 64'd0) begin
                                    r_res  <= '0;
                                    r_done <= 1'b1;
                                end else if ({32'd0, ua[63:32]} >= ub) begin
                                    r_res  <= from_mag(neg, '1);
                                    r_done <= 1'b1;
                                end else begin
                                    r_rem   <= {32'd0, ua[63:32]};
                                    r_lo    <= {ua[31:0], 32'd0};
                                    r_q     <= '0;
                                    r_dcnt  <= '0;
                                    r_state <= A_DIV;
                                end
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_mcnt != 3'd4) begin
                        r_pp   <= 64'(pa) * 64'(pb);
                        r_ppsh <= psh;
                    end
                    if (r_mcnt != 3'd0) begin
                        r_acc <= r_acc + ({64'd0, r_pp} << (7'd32 * 7'(r_ppsh)));
                    end
                    if (r_mcnt == 3'd4) begin
                        r_state <= A_MFIN;
                    end
                    r_mcnt <= r_mcnt + 3'd1;
                end
                A_MFIN: begin
                    r_res   <= (r_acc[127:96] != 32'd0) ? from_mag(r_neg, '1)
                                                        : from_mag(r_neg, r_acc[95:32]);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    if (rr >= {1'b0, r_ub}) begin
                        r_rem <= 64'(rr - {1'b0, r_ub});
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= rr[63:0];
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_lo   <= {r_lo[62:0], 1'b0};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) begin
                        r_state <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    r_res   <= from_mag(r_neg, r_q);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

/* src/conic_fit_and_classify.sv */
// Conic fit through five points and classification by invariants.
//
// A request on i_req carries five integer points. The block builds the 5x5
// system in a 64-entry scratch RAM, eliminates with partial pivoting, back
// substitutes, forms I1, I2, I3, K and picks one of nine conic kinds.
// i_req.ready is high only while the block is idle; one request is worked
// at a time. The shared ALU does all arithmetic: fifteen 64-step divisions
// plus 88 four-step multiplies per request (fewer when the system turns out
// singular), each operand fetched through the single RAM read port.
// The result sits in an output register; the next request is accepted while
// it waits, and a finished result stalls only if the previous one is still
// not taken. Reset returns the sequencer to idle, drops o_res.valid and sets
// the zero tolerance to 16; the RAM is not cleared. i_cfg_we writes the
// tolerance and is to be used only while idle; the block itself does not
// enforce this.
module conic_fit_and_classify #(
    parameter int COORD_WIDTH = cfc_pkg::COORD_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cfc_pkg::TOL_W-1:0]  i_cfg_data,
    cfc_in_if.sink                     i_req,
    cfc_out_if.source                  o_res
);
    typedef enum logic [5:0] {
        S_IDLE, S_LOAD, S_LWR, S_LHALF,
        S_PRD, S_PCMP, S_PCHK,
        S_SRA, S_SRB, S_SWA, S_SWB,
        S_ERP, S_ECP, S_ERF, S_EDIV, S_EDVD, S_ERC, S_EMUL, S_EMLD, S_ESUB, S_ESBD,
        S_BRD5, S_BCAP, S_BRJ, S_BRS, S_BMUL, S_BSUB, S_BSBD, S_BRDD, S_BDIV, S_BDVD,
        S_URA, S_URB, S_UGO, S_UWR,
        S_WAIT, S_CLASS, S_SING, S_DONE
    } t_state;

    localparam int AW = cfc_pkg::MEM_AW;

    t_state                          r_state;
    t_state                          r_ret;
    logic [cfc_pkg::TOL_W-1:0]       r_tol;
    logic signed [COORD_WIDTH-1:0]   r_px [cfc_pkg::NROW];
    logic signed [COORD_WIDTH-1:0]   r_py [cfc_pkg::NROW];
    logic [2:0]                      r_row;
    logic [2:0]                      r_col;
    logic [2:0]                      r_j;
    logic [2:0]                      r_best;
    logic [63:0]                     r_bestmag;
    logic [63:0]                     r_piv;
    logic [63:0]                     r_f;
    logic [63:0]                     r_t;
    logic [63:0]                     r_s;
    logic [63:0]                     r_tmp;
    logic [63:0]                     r_opa;
    logic [cfc_pkg::PC_W-1:0]        r_pc;
    logic signed [63:0]              r_i1;
    logic signed [63:0]              r_i2;
    logic signed [63:0]              r_i3;
    logic signed [63:0]              r_k;
    logic [cfc_pkg::KIND_W-1:0]      r_kind;
    logic                            r_sing;
    logic                            r_ovalid;
    logic [cfc_pkg::KIND_W-1:0]      r_okind;
    logic                            r_osing;
    logic signed [63:0]              r_oi1;
    logic signed [63:0]              r_oi2;
    logic signed [63:0]              r_oi3;
    logic signed [63:0]              r_ok;

    cfc_pkg::t_alu_req  alu_req;
    cfc_pkg::t_alu_rsp  alu_rsp;
    cfc_pkg::t_ustep    ustep;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [63:0]        wdata;
    logic [AW-1:0]      raddr;
    logic [63:0]        rd_data;
    logic [63:0]        qx;
    logic [63:0]        qy;
    logic [63:0]        rd_mag;
    logic [cfc_pkg::KIND_W-1:0] kind;

    function automatic logic [AW-1:0] maddr(input logic [2:0] row, input logic [2:0] col);
        return AW'(row) * AW'(cfc_pkg::NCOL) + AW'(col);
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] to_q(input logic signed [COORD_WIDTH-1:0] c);
        return {{(32 - COORD_WIDTH){c[COORD_WIDTH-1]}}, c, 32'd0};
    endfunction

    function automatic logic is_zero(input logic [63:0] v, input logic [31:0] tol);
        return mag(v) < {32'd0, tol};
    endfunction

    cfc_ram #(
        .WIDTH (cfc_pkg::Q_W),
        .DEPTH (cfc_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    cfc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        qx     = to_q(r_px[r_row]);
        qy     = to_q(r_py[r_row]);
        ustep  = cfc_pkg::prog_step(r_pc);
        rd_mag = mag(rd_data);
        alu_req = '{start: 1'b0, op: cfc_pkg::ALU_ADD, a: '0, b: '0};
        we     = 1'b0;
        waddr  = '0;
        wdata  = '0;
        raddr  = '0;
        case (r_state)
            S_LOAD: begin
                if (r_j < 3'd3) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = cfc_pkg::ALU_MUL;
                    alu_req.a     = (r_j == 3'd2) ? qy : qx;
                    alu_req.b     = (r_j == 3'd0) ? qx : qy;
                end else begin
                    we    = 1'b1;
                    waddr = maddr(r_row, r_j);
                    wdata = (r_j == 3'd3) ? qx : (r_j == 3'd4) ? qy : cfc_pkg::Q_NEG_ONE;
                end
            end
            S_LWR: begin
                we    = 1'b1;
                waddr = maddr(r_row, r_j);
                wdata = alu_rsp.res;
            end
            S_LHALF: begin
                we    = 1'b1;
                waddr = cfc_pkg::A_HALF;
                wdata = cfc_pkg::Q_HALF;
            end
            S_PRD:  raddr = maddr(r_row, r_col);
            S_SRA:  raddr = maddr(r_col, r_j);
            S_SRB:  raddr = maddr(r_best, r_j);
            S_SWA: begin
                we    = 1'b1;
                waddr = maddr(r_col, r_j);
                wdata = rd_data;
            end
            S_SWB: begin
                we    = 1'b1;
                waddr = maddr(r_best, r_j);
                wdata = r_tmp;
            end
            S_ERP:  raddr = maddr(r_col, r_col);
            S_ERF:  raddr = maddr(r_row, r_col);
            S_EDIV: alu_req = '{1'b1, cfc_pkg::ALU_DIV, rd_data, r_piv};
            S_ERC:  raddr = maddr(r_col, r_j);
            S_EMUL: alu_req = '{1'b1, cfc_pkg::ALU_MUL, r_f, rd_data};
            S_EMLD: raddr = maddr(r_row, r_j);
            S_ESUB: alu_req = '{1'b1, cfc_pkg::ALU_SUB, rd_data, r_t};
            S_ESBD: begin
                we    = 1'b1;
                waddr = maddr(r_row, r_j);
                wdata = alu_rsp.res;
            end
            S_BRD5: raddr = maddr(r_col, 3'd5);
            S_BRJ:  raddr = maddr(r_col, r_j);
            S_BRS:  raddr = cfc_pkg::A_S0 + AW'(r_j);
            S_BMUL: alu_req = '{1'b1, cfc_pkg::ALU_MUL, r_tmp, rd_data};
            S_BSUB: alu_req = '{1'b1, cfc_pkg::ALU_SUB, r_s, alu_rsp.res};
            S_BRDD: raddr = maddr(r_col, r_col);
            S_BDIV: alu_req = '{1'b1, cfc_pkg::ALU_DIV, r_s, rd_data};
            S_BDVD: begin
                we    = 1'b1;
                waddr = cfc_pkg::A_S0 + AW'(r_col);
                wdata = alu_rsp.res;
            end
            S_URA:  raddr = ustep.a;
            S_URB:  raddr = ustep.b;
            S_UGO:  alu_req = '{1'b1, ustep.op, r_opa, rd_data};
            S_UWR: begin
                we    = 1'b1;
                waddr = ustep.dst;
                wdata = alu_rsp.res;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (is_zero(r_i2, r_tol)) begin
            if (is_zero(r_i3, r_tol)) begin
                if (is_zero(r_k, r_tol)) begin
                    kind = cfc_pkg::KIND_COINCIDENT;
                end else begin
                    kind = (r_k > 0) ? cfc_pkg::KIND_IMAG_PAR : cfc_pkg::KIND_PARALLEL;
                end
            end else begin
                kind = cfc_pkg::KIND_PARABOLA;
            end
        end else if (r_i2 > 0) begin
            if (is_zero(r_i3, r_tol)) begin
                kind = cfc_pkg::KIND_POINT;
            end else if ((r_i1 < 0 && r_i3 > 0) || (r_i1 > 0 && r_i3 < 0)) begin
                kind = cfc_pkg::KIND_ELLIPSE;
            end else begin
                kind = cfc_pkg::KIND_IMAG_ELL;
            end
        end else begin
            kind = is_zero(r_i3, r_tol) ? cfc_pkg::KIND_CROSSING : cfc_pkg::KIND_HYPERBOLA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_tol    <= cfc_pkg::TOL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (r_ovalid && o_res.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_px[0] <= i_req.x0; r_py[0] <= i_req.y0;
                        r_px[1] <= i_req.x1; r_py[1] <= i_req.y1;
                        r_px[2] <= i_req.x2; r_py[2] <= i_req.y2;
                        r_px[3] <= i_req.x3; r_py[3] <= i_req.y3;
                        r_px[4] <= i_req.x4; r_py[4] <= i_req.y4;
                        r_row   <= '0;
                        r_j     <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_j < 3'd3) begin
                        r_ret   <= S_LWR;
                        r_state <= S_WAIT;
                    end else if (r_j == 3'd5) begin
                        r_j <= '0;
                        if (r_row == 3'd4) begin
                            r_state <= S_LHALF;
                        end else begin
                            r_row <= r_row + 3'd1;
                        end
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                S_LWR: begin
                    r_j     <= r_j + 3'd1;
                    r_state <= S_LOAD;
                end
                S_LHALF: begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PCMP;
                S_PCMP: begin
                    if (r_row == r_col || rd_mag > r_bestmag) begin
                        r_best    <= r_row;
                        r_bestmag <= rd_mag;
                    end
                    if (r_row == 3'd4) begin
                        r_state <= S_PCHK;
                    end else begin
                        r_row   <= r_row + 3'd1;
                        r_state <= S_PRD;
                    end
                end
                S_PCHK: begin
                    if (r_bestmag == 64'd0 || r_bestmag < {32'd0, r_tol}) begin
                        r_state <= S_SING;
                    end else if (r_best != r_col) begin
                        r_j     <= r_col;
                        r_state <= S_SRA;
                    end else begin
                        r_state <= S_ERP;
                    end
                end
                S_SRA: r_state <= S_SRB;
                S_SRB: begin
                    r_tmp   <= rd_data;
                    r_state <= S_SWA;
                end
                S_SWA: r_state <= S_SWB;
                S_SWB: begin
                    if (r_j == 3'd5) begin
                        r_state <= S_ERP;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_SRA;
                    end
                end
                S_ERP: begin
                    r_row   <= r_col + 3'd1;
                    r_state <= S_ECP;
                end
                S_ECP: begin
                    r_piv   <= rd_data;
                    r_state <= (r_col == 3'd4) ? S_BRD5 : S_ERF;
                end
                S_ERF: r_state <= S_EDIV;
                S_EDIV: begin
                    r_ret   <= S_EDVD;
                    r_state <= S_WAIT;
                end
                S_EDVD: begin
                    r_f     <= alu_rsp.res;
                    r_j     <= r_col;
                    r_state <= S_ERC;
                end
                S_ERC: r_state <= S_EMUL;
                S_EMUL: begin
                    r_ret   <= S_EMLD;
                    r_state <= S_WAIT;
                end
                S_EMLD: begin
                    r_t     <= alu_rsp.res;
                    r_state <= S_ESUB;
                end
                S_ESUB: begin
                    r_ret   <= S_ESBD;
                    r_state <= S_WAIT;
                end
                S_ESBD: begin
                    if (r_j != 3'd5) begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_ERC;
                    end else if (r_row != 3'd4) begin
                        r_row   <= r_row + 3'd1;
                        r_state <= S_ERF;
                    end else begin
                        r_col   <= r_col + 3'd1;
                        r_row   <= r_col + 3'd1;
                        r_state <= S_PRD;
                    end
                end
                S_BRD5: r_state <= S_BCAP;
                S_BCAP: begin
                    r_s     <= rd_data;
                    r_j     <= r_col + 3'd1;
                    r_state <= (r_col == 3'd4) ? S_BRDD : S_BRJ;
                end
                S_BRJ: r_state <= S_BRS;
                S_BRS: begin
                    r_tmp   <= rd_data;
                    r_state <= S_BMUL;
                end
                S_BMUL: begin
                    r_ret   <= S_BSUB;
                    r_state <= S_WAIT;
                end
                S_BSUB: begin
                    r_ret   <= S_BSBD;
                    r_state <= S_WAIT;
                end
                S_BSBD: begin
                    r_s <= alu_rsp.res;
                    if (r_j == 3'd4) begin
                        r_state <= S_BRDD;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_BRJ;
                    end
                end
                S_BRDD: r_state <= S_BDIV;
                S_BDIV: begin
                    r_ret   <= S_BDVD;
                    r_state <= S_WAIT;
                end
                S_BDVD: begin
                    if (r_col == 3'd0) begin
                        r_pc    <= '0;
                        r_state <= S_URA;
                    end else begin
                        r_col   <= r_col - 3'd1;
                        r_state <= S_BRD5;
                    end
                end
                S_URA: r_state <= S_URB;
                S_URB: begin
                    r_opa   <= rd_data;
                    r_state <= S_UGO;
                end
                S_UGO: begin
                    r_ret   <= S_UWR;
                    r_state <= S_WAIT;
                end
                S_UWR: begin
                    if (ustep.dst == cfc_pkg::A_I1) r_i1 <= alu_rsp.res;
                    if (ustep.dst == cfc_pkg::A_I2) r_i2 <= alu_rsp.res;
                    if (ustep.dst == cfc_pkg::A_I3) r_i3 <= alu_rsp.res;
                    if (ustep.dst == cfc_pkg::A_K)  r_k  <= alu_rsp.res;
                    if (r_pc == cfc_pkg::PC_W'(cfc_pkg::PROG_LEN - 1)) begin
                        r_state <= S_CLASS;
                    end else begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_URA;
                    end
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        r_state <= r_ret;
                    end
                end
                S_CLASS: begin
                    r_kind  <= kind;
                    r_sing  <= 1'b0;
                    r_state <= S_DONE;
                end
                S_SING: begin
                    r_kind  <= cfc_pkg::KIND_COINCIDENT;
                    r_sing  <= 1'b1;
                    r_i1    <= '0;
                    r_i2    <= '0;
                    r_i3    <= '0;
                    r_k     <= '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_kind;
                        r_osing  <= r_sing;
                        r_oi1    <= r_i1;
                        r_oi2    <= r_i2;
                        r_oi3    <= r_i3;
                        r_ok     <= r_k;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.conic_kind   = r_okind;
    assign o_res.singular     = r_osing;
    assign o_res.inv_trace    = r_oi1;
    assign o_res.inv_quad_det = r_oi2;
    assign o_res.inv_full_det = r_oi3;
    assign o_res.inv_semi     = r_ok;
endmodule

/* src/cfc_chk.sv */
// Port-level checks for the conic fit block, bound to the top level.
module cfc_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cfc_pkg::KIND_W-1:0] i_kind,
    input logic                       i_singular,
    input logic [cfc_pkg::Q_W-1:0]    i_inv_trace,
    input logic [cfc_pkg::Q_W-1:0]    i_inv_quad_det,
    input logic [cfc_pkg::Q_W-1:0]    i_inv_full_det,
    input logic [cfc_pkg::Q_W-1:0]    i_inv_semi
);
    a_sing_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_singular) |-> (i_kind == cfc_pkg::KIND_COINCIDENT &&
            i_inv_trace == '0 && i_inv_quad_det == '0 && i_inv_full_det == '0 &&
            i_inv_semi == '0))
        else $error("singular result with nonzero fields");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind <= cfc_pkg::KIND_HYPERBOLA))
        else $error("conic kind out of range");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready while a request is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind) &&
            $stable(i_inv_full_det)))
        else $error("stalled result changed");
endmodule

bind conic_fit_and_classify cfc_chk u_cfc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.conic_kind),
    .i_singular     (o_res.singular),
    .i_inv_trace    (o_res.inv_trace),
    .i_inv_quad_det (o_res.inv_quad_det),
    .i_inv_full_det (o_res.inv_full_det),
    .i_inv_semi     (o_res.inv_semi)
);
